// File: design/qvr_pkg.sv
package qvr_pkg;

    // Travels with every item through the whole pipeline.
    typedef struct packed {
        logic valid;
        logic zero;
    } qvr_tag_t;

endpackage

// File: design/qvr_div3.sv
module qvr_div3 #(
    parameter int W  = 16,
    parameter int NW = 3 * W + 4,
    parameter int DW = 2 * W + 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  qvr_pkg::qvr_tag_t     tag_in,
    input  logic signed [NW-1:0]  num_in [3],
    input  logic        [DW-1:0]  den_in,
    output qvr_pkg::qvr_tag_t     tag_out,
    output logic signed [W-1:0]   res_out [3]
);

    localparam int RW = NW + 1;
    localparam int S  = W + 2;
    localparam int QW = W + 1;

    logic [RW-1:0]   rem_reg [S][3];
    logic [QW-1:0]   q_reg   [S][3];
    logic            neg_reg [S][3];
    logic [DW:0]     d2_reg  [S];
    qvr_pkg::qvr_tag_t tag_reg [S];
    qvr_pkg::qvr_tag_t tag_out_reg;
    logic signed [W-1:0] res_reg [3];

    logic [NW-1:0] mag [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag[k] = num_in[k][NW-1] ? NW'(-num_in[k]) : NW'(num_in[k]);
        end
    end

    // Rounding is folded in: quotient of (2|N| + n) by 2n.
    always_ff @(posedge aclk) begin
        if (en) begin
            d2_reg[0] <= {den_in, 1'b0};
            for (int k = 0; k < 3; k++) begin
                rem_reg[0][k] <= {mag[k], 1'b0} + RW'(den_in);
                q_reg[0][k]   <= '0;
                neg_reg[0][k] <= num_in[k][NW-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg[0] <= '0;
        end else if (en) begin
            tag_reg[0] <= tag_in;
        end
    end

    for (genvar i = 1; i < S; i++) begin : g_step
        localparam int B = W + 1 - i;
        logic [RW-1:0] dsh;
        logic          ge [3];

        assign dsh = RW'(d2_reg[i-1]) << B;

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                ge[k] = rem_reg[i-1][k] >= dsh;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d2_reg[i] <= d2_reg[i-1];
                for (int k = 0; k < 3; k++) begin
                    rem_reg[i][k] <= ge[k] ? rem_reg[i-1][k] - dsh : rem_reg[i-1][k];
                    q_reg[i][k]   <= {q_reg[i-1][k][QW-2:0], ge[k]};
                    neg_reg[i][k] <= neg_reg[i-1][k];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[i] <= '0;
            end else if (en) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    logic signed [W-1:0] res_next [3];
    localparam logic [QW-1:0] HALF = QW'(1) << (W - 1);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (neg_reg[S-1][k]) begin
                res_next[k] = (q_reg[S-1][k] > HALF) ? {1'b1, {(W-1){1'b0}}}
                                                     : W'(-q_reg[S-1][k]);
            end else begin
                res_next[k] = (q_reg[S-1][k] >= HALF) ? {1'b0, {(W-1){1'b1}}}
                                                      : W'(q_reg[S-1][k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                res_reg[k] <= res_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_out_reg <= '0;
        end else if (en) begin
            tag_out_reg <= tag_reg[S-1];
        end
    end

    assign tag_out = tag_out_reg;
    assign res_out = res_reg;

endmodule

// File: design/quaternion_vector_rotate_core.sv
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   quat_x/y/z/w, vec_x/y/z
// m_        out        m_valid / m_ready   rot_x/y/z, zero_quat_error
//
// One item enters per cycle while no result waits on m_ready.
// The rounding divider produces one quotient bit per stage.
// The whole pipeline advances together; s_ready falls only while a result
// waits on m_ready, and nothing is lost or repeated across a stall.
// Reset clears all valid bits; data registers carry no reset.
module quaternion_vector_rotate_core #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COMPONENT_WIDTH-1:0] s_quat_x,
    input  logic signed [COMPONENT_WIDTH-1:0] s_quat_y,
    input  logic signed [COMPONENT_WIDTH-1:0] s_quat_z,
    input  logic signed [COMPONENT_WIDTH-1:0] s_quat_w,
    input  logic signed [COMPONENT_WIDTH-1:0] s_vec_x,
    input  logic signed [COMPONENT_WIDTH-1:0] s_vec_y,
    input  logic signed [COMPONENT_WIDTH-1:0] s_vec_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [COMPONENT_WIDTH-1:0] m_rot_x,
    output logic signed [COMPONENT_WIDTH-1:0] m_rot_y,
    output logic signed [COMPONENT_WIDTH-1:0] m_rot_z,
    output logic                              m_zero_quat_error
);

    localparam int W  = COMPONENT_WIDTH;
    localparam int PW = 2 * W;
    localparam int CW = 2 * W + 2;
    localparam int MW = CW + W;
    localparam int NW = 3 * W + 4;
    localparam int DW = 2 * W + 1;

    logic en;
    qvr_pkg::qvr_tag_t tag_in, tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag_out;

    assign en = !tag_out.valid || m_ready;
    assign s_ready = en;

    // An all-zero quaternion is exactly the case of zero norm.
    assign tag_in.valid = s_valid;
    assign tag_in.zero  = (s_quat_x == '0) && (s_quat_y == '0) &&
                          (s_quat_z == '0) && (s_quat_w == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end else if (en) begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    // Stage 1: quaternion products.
    logic signed [PW-1:0] xx_reg, yy_reg, zz_reg, ww_reg, xy_reg, xz_reg, yz_reg;
    logic signed [PW-1:0] wx_reg, wy_reg, wz_reg;
    logic signed [W-1:0]  v1_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg <= s_quat_x * s_quat_x;
            yy_reg <= s_quat_y * s_quat_y;
            zz_reg <= s_quat_z * s_quat_z;
            ww_reg <= s_quat_w * s_quat_w;
            xy_reg <= s_quat_x * s_quat_y;
            xz_reg <= s_quat_x * s_quat_z;
            yz_reg <= s_quat_y * s_quat_z;
            wx_reg <= s_quat_w * s_quat_x;
            wy_reg <= s_quat_w * s_quat_y;
            wz_reg <= s_quat_w * s_quat_z;
            v1_reg[0] <= s_vec_x;
            v1_reg[1] <= s_vec_y;
            v1_reg[2] <= s_vec_z;
        end
    end

    // Stage 2: rotation matrix entries scaled by the squared norm, and the squared norm.
    logic signed [CW-1:0] c_reg [9];
    logic        [DW-1:0] n2_reg;
    logic signed [W-1:0]  v2_reg [3];
    logic signed [CW-1:0] exx, eyy, ezz, eww, exy, exz, eyz, ewx, ewy, ewz;

    assign exx = CW'(xx_reg);
    assign eyy = CW'(yy_reg);
    assign ezz = CW'(zz_reg);
    assign eww = CW'(ww_reg);
    assign exy = CW'(xy_reg);
    assign exz = CW'(xz_reg);
    assign eyz = CW'(yz_reg);
    assign ewx = CW'(wx_reg);
    assign ewy = CW'(wy_reg);
    assign ewz = CW'(wz_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg[0] <= eww + exx - eyy - ezz;
            c_reg[1] <= (exy - ewz) <<< 1;
            c_reg[2] <= (exz + ewy) <<< 1;
            c_reg[3] <= (exy + ewz) <<< 1;
            c_reg[4] <= eww - exx + eyy - ezz;
            c_reg[5] <= (eyz - ewx) <<< 1;
            c_reg[6] <= (exz - ewy) <<< 1;
            c_reg[7] <= (eyz + ewx) <<< 1;
            c_reg[8] <= eww - exx - eyy + ezz;
            n2_reg   <= DW'($unsigned(xx_reg)) + DW'($unsigned(yy_reg)) +
                        DW'($unsigned(zz_reg)) + DW'($unsigned(ww_reg));
            v2_reg   <= v1_reg;
        end
    end

    // Stage 3: matrix times vector, one product per entry.
    logic signed [MW-1:0] p_reg [9];
    logic        [DW-1:0] n3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    p_reg[k*3+j] <= c_reg[k*3+j] * v2_reg[j];
                end
            end
            n3_reg <= n2_reg;
        end
    end

    // Stage 4: row sums.
    logic signed [NW-1:0] num_reg [3];
    logic        [DW-1:0] n4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                num_reg[k] <= NW'(p_reg[k*3]) + NW'(p_reg[k*3+1]) + NW'(p_reg[k*3+2]);
            end
            n4_reg <= n3_reg;
        end
    end

    logic signed [W-1:0] res [3];

    qvr_div3 #(
        .W  (W),
        .NW (NW),
        .DW (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .tag_in  (tag4_reg),
        .num_in  (num_reg),
        .den_in  (n4_reg),
        .tag_out (tag_out),
        .res_out (res)
    );

    assign m_valid           = tag_out.valid;
    assign m_zero_quat_error = tag_out.zero;
    assign m_rot_x           = tag_out.zero ? '0 : res[0];
    assign m_rot_y           = tag_out.zero ? '0 : res[1];
    assign m_rot_z           = tag_out.zero ? '0 : res[2];

    a_ready_follows_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow the output stall");

    a_stall_holds_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rot_x) && $stable(m_zero_quat_error))
        else $error("stalled result changed");

    a_zero_gives_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_quat_error |-> m_rot_x == '0 && m_rot_y == '0 && m_rot_z == '0)
        else $error("zero quaternion gave nonzero result");

    a_stage_tag_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(tag4_reg))
        else $error("pipeline moved during a stall");

endmodule

// File: bench/testbench.sv
module testbench;

    localparam int W = 16;
    localparam int N_RANDOM = 1030;
    localparam int TAIL_CYCLES = 4 * (W + 7) + 20;

    typedef struct {
        logic signed [W-1:0] rx;
        logic signed [W-1:0] ry;
        logic signed [W-1:0] rz;
        logic                zq;
    } rotation_t;

    int unsigned mismatch_count = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Exact rotation: round(N/n) to nearest, ties away from zero, then saturate.
    function automatic logic signed [W-1:0] round_sat(input logic signed [127:0] num,
                                                      input logic signed [127:0] den);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        logic                neg;
        neg = num < 0;
        mag = neg ? -num : num;
        q = (2 * mag + den) / (2 * den);
        if (neg) q = -q;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[W-1:0];
    endfunction

    function automatic rotation_t rotate_vector(input logic signed [W-1:0] x, y, z, w,
                                                input logic signed [W-1:0] vx, vy, vz);
        rotation_t r;
        logic signed [127:0] qx, qy, qz, qw, ax, ay, az, n, nx, ny, nz;
        qx = x; qy = y; qz = z; qw = w; ax = vx; ay = vy; az = vz;
        n = qx*qx + qy*qy + qz*qz + qw*qw;
        if (n == 0) begin
            r.rx = 0; r.ry = 0; r.rz = 0; r.zq = 1'b1;
            return r;
        end
        nx = (qw*qw + qx*qx - qy*qy - qz*qz) * ax + 2*(qx*qy - qw*qz) * ay
           + 2*(qx*qz + qw*qy) * az;
        ny = 2*(qx*qy + qw*qz) * ax + (qw*qw - qx*qx + qy*qy - qz*qz) * ay
           + 2*(qy*qz - qw*qx) * az;
        nz = 2*(qx*qz - qw*qy) * ax + 2*(qy*qz + qw*qx) * ay
           + (qw*qw - qx*qx - qy*qy + qz*qz) * az;
        r.rx = round_sat(nx, n);
        r.ry = round_sat(ny, n);
        r.rz = round_sat(nz, n);
        r.zq = 1'b0;
        return r;
    endfunction

    class rotation_scoreboard;
        rotation_t pending[$];
        int unsigned checked = 0;
        int unsigned zero_seen = 0;

        function void note_input(rotation_t r);
            pending.push_back(r);
        endfunction

        task check_result(rotation_t got);
            rotation_t want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.zq) zero_seen++;
            if (got.rx !== want.rx) report_mismatch("rot_x", got.rx, want.rx);
            if (got.ry !== want.ry) report_mismatch("rot_y", got.ry, want.ry);
            if (got.rz !== want.rz) report_mismatch("rot_z", got.rz, want.rz);
            if (got.zq !== want.zq) report_mismatch("zero_quat_error", got.zq, want.zq);
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [W-1:0] s_quat_x = '0, s_quat_y = '0, s_quat_z = '0, s_quat_w = '0;
    logic signed [W-1:0] s_vec_x = '0, s_vec_y = '0, s_vec_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [W-1:0] m_rot_x, m_rot_y, m_rot_z;
    logic m_zero_quat_error;

    rotation_scoreboard board = new();
    bit quiet_mode = 0;
    bit hold_off = 0;
    bit stimulus_done = 0;

    quaternion_vector_rotate_core #(.COMPONENT_WIDTH(W)) uut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("quaternion_vector_rotate_core regression: fail");
        $finish;
    end

    function automatic logic signed [W-1:0] random_field();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'sh4000;
            default: return W'($urandom());
        endcase
    endfunction

    // Offers one item from the falling edge and holds it until accepted.
    // Valid drops only while the sender idles between items.
    task automatic send_item(input logic signed [W-1:0] x, y, z, w, vx, vy, vz);
        if (!quiet_mode) begin
            while ($urandom_range(0, 99) < 38) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_quat_x <= x; s_quat_y <= y; s_quat_z <= z; s_quat_w <= w;
        s_vec_x <= vx; s_vec_y <= vy; s_vec_z <= vz;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        board.note_input(rotate_vector(x, y, z, w, vx, vy, vz));
        @(negedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // Identity, zero quaternion, extremes, 90 degree turns, non-unit norms.
        send_item(0, 0, 0, 16'sh4000, 100, -200, 300);
        send_item(0, 0, 0, 0, 1234, 5, 6);
        send_item(0, 0, 0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_item(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(0, 0, 16'sh2d41, 16'sh2d41, 1000, 0, 0);
        send_item(16'sh2d41, 0, 0, 16'sh2d41, 0, 1000, 0);
        send_item(0, 16'sh2d41, 0, 16'sh2d41, 0, 0, 1000);
        send_item(1, 0, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_item(1, 1, 1, 1, 16'sh8000, 16'sh7fff, 16'sh8000);
        send_item(16'sh8000, 0, 0, 0, 3, -3, 7);
        send_item(0, 0, 0, 16'sh8000, 16'sh8000, 0, 16'sh7fff);
        send_item(1, 2, 3, 4, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_item(0, 0, 0, 1, 5, 16'shffff, 1);
        send_item(3, 0, 0, 1, 1, 1, 1);
        for (int i = 0; i < N_RANDOM; i++) begin
            quiet_mode = (i >= 300 && i < 450);
            if (i == 600) hold_off = 1;
            send_item(random_field(), random_field(), random_field(), random_field(),
                      random_field(), random_field(), random_field());
        end
        s_valid <= 1'b0;
        stimulus_done = 1;
    end

    // Receiver: random stalls, one quiet stretch, and one long hold-off.
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (200) @(negedge aclk);
                hold_off = 0;
            end
            m_ready <= quiet_mode || ($urandom_range(0, 99) >= 38);
        end
    end

    always @(posedge aclk) begin
        rotation_t got;
        if (aresetn && m_valid && m_ready) begin
            got.rx = m_rot_x; got.ry = m_rot_y; got.rz = m_rot_z; got.zq = m_zero_quat_error;
            board.check_result(got);
        end
    end

    initial begin
        wait (stimulus_done);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Checked %0d rotations, %0d with a zero quaternion, under random stalls.",
                 board.checked, board.zero_seen);
        if (mismatch_count == 0 && board.pending.size() == 0)
            $display("quaternion_vector_rotate_core regression: pass");
        else
            $display("quaternion_vector_rotate_core regression: fail");
        $finish;
    end

endmodule
